/* design/wre_pkg.sv */
// wre_pkg: shared widths, register indexes, control struct and 48-bit clip helper
// used by every file of the wendland rbf evaluator; depends on nothing
package wre_pkg;

   localparam int NUM_COEFS_DEF = 6;
   localparam int FRAC_BITS_DEF = 24;
   localparam int VALUE_W       = 48;
   localparam int DIST_W        = 32;
   localparam int REG_COEFS     = 6;
   localparam int CSR_INDEX_W   = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_SCALE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RECIP = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF0 = 4'd2;

   localparam logic [DIST_W-1:0]         SCALE_RESET = 32'h0100_0000;
   localparam logic signed [VALUE_W-1:0] POS_MAX     = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [VALUE_W-1:0] NEG_MIN     = 48'sh8000_0000_0000;
   localparam logic [VALUE_W:0]          MAG_CAP     = 49'h1_0000_0000_0000;

   typedef struct packed {
      logic valid;
      logic outside;
      logic rzero;
      logic flag;
   } ctl_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      clipped;
   } clip_type;

   function automatic clip_type clip_sum(input logic signed [VALUE_W+2:0] v);
      clip_type c;
      c.clipped = 1'b1;
      c.value   = POS_MAX;
      if (v > (VALUE_W+3)'(POS_MAX)) begin
         c.value = POS_MAX;
      end else if (v < (VALUE_W+3)'(NEG_MIN)) begin
         c.value = NEG_MIN;
      end else begin
         c.value   = v[VALUE_W-1:0];
         c.clipped = 1'b0;
      end
      return c;
   endfunction

endpackage

/* design/wendland_rbf_evaluator_top.sv */
// wendland_rbf_evaluator_top: support test, pipelined horner chain, pipelined divider
// depends on wre_pkg, wre_horner_stage, wre_div_stage
//
//  channel   direction  payload
//  req_      in         tdata[31:0] distance
//  rsp_      out        tdata[47:0] value, tuser[0] saturated
//  csr_      in         index, data (write only)
//
// registers in order: front f1 and f2, horner stages, divider stages, result register
// one distance per cycle unless stalled; each divider stage is a single register step
// every stage advances together while the result register is empty or taken
// reset clears valid bits and loads register defaults
module wendland_rbf_evaluator_top #(
   parameter int NUM_COEFS = wre_pkg::NUM_COEFS_DEF,
   parameter int FRAC_BITS = wre_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,   // distance
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [47:0]                         rsp_tdata,   // value
   output logic [0:0]                          rsp_tuser,   // saturated
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wre_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [47:0]                         csr_data
);
   localparam int VW = wre_pkg::VALUE_W;
   localparam int RW = wre_pkg::DIST_W;
   localparam int HN = NUM_COEFS - 1;
   localparam int DW = VW + FRAC_BITS;
   localparam int CW = $clog2(wre_pkg::REG_COEFS);

   logic                 en;
   logic [RW-1:0]        scale_ff;
   logic                 recip_ff;
   logic signed [VW-1:0] coef_ff [wre_pkg::REG_COEFS];
   logic signed [VW-1:0] coef_sel [NUM_COEFS];
   logic [VW-1:0]        m0;

   logic                 f1_valid_ff;
   logic [RW-1:0]        f1_r_ff;
   logic [2*RW-1:0]      f1_prod_ff;
   wre_pkg::ctl_type     f2_ctl_ff, f2_ctl_in;
   logic [RW-1:0]        f2_r_ff;
   logic signed [VW-1:0] f2_acc_ff;

   wre_pkg::ctl_type     h_ctl [HN+1];
   logic signed [VW-1:0] h_acc [HN+1];
   logic [RW-1:0]        h_r   [HN+1];

   wre_pkg::ctl_type     d_ctl [DW+1];
   logic signed [VW-1:0] d_acc [DW+1];
   logic [RW-1:0]        d_r   [DW+1];
   logic [RW-1:0]        d_rem [DW+1];
   logic [DW-1:0]        d_q   [DW+1];

   logic                 rnd;
   logic [DW:0]          res_full;
   logic [VW:0]          res;
   logic signed [VW+1:0] sres;
   wre_pkg::clip_type    clip;
   logic                 out_valid_ff;
   logic signed [VW-1:0] out_value_ff, out_value_in;
   logic                 out_sat_ff, out_sat_in;

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= wre_pkg::SCALE_RESET;
         recip_ff <= 1'b0;
         for (int i = 0; i < wre_pkg::REG_COEFS; i++) coef_ff[i] <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            wre_pkg::REG_SCALE: scale_ff <= csr_data[RW-1:0];
            wre_pkg::REG_RECIP: recip_ff <= csr_data[0];
            default: begin
               if (csr_index >= wre_pkg::REG_COEF0 &&
                   csr_index < wre_pkg::REG_COEF0 + wre_pkg::CSR_INDEX_W'(wre_pkg::REG_COEFS))
                  coef_ff[CW'(csr_index - wre_pkg::REG_COEF0)] <= csr_data;
            end
         endcase
      end
   end

   for (genvar p = 0; p < NUM_COEFS; p++) begin : g_coef
      if (p < wre_pkg::REG_COEFS) begin : g_reg
         assign coef_sel[p] = coef_ff[p];
      end else begin : g_zero
         assign coef_sel[p] = '0;
      end
   end

   assign m0 = coef_ff[0][VW-1] ? VW'(-coef_ff[0]) : VW'(coef_ff[0]);

   // front: support product, then support and zero-distance tests
   always_comb begin
      f2_ctl_in.valid   = f1_valid_ff;
      f2_ctl_in.outside = (f1_prod_ff >> (2 * FRAC_BITS)) != '0;
      f2_ctl_in.rzero   = recip_ff && (f1_r_ff == '0);
      f2_ctl_in.flag    = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_ctl_ff   <= '0;
      end else if (en) begin
         f1_valid_ff <= req_tvalid;
         f2_ctl_ff   <= f2_ctl_in;
      end
      if (en) begin
         f1_r_ff    <= req_tdata;
         f1_prod_ff <= (2*RW)'(scale_ff) * (2*RW)'(req_tdata);
         f2_r_ff    <= f1_r_ff;
         f2_acc_ff  <= coef_sel[NUM_COEFS-1];
      end
   end

   assign h_ctl[0] = f2_ctl_ff;
   assign h_acc[0] = f2_acc_ff;
   assign h_r[0]   = f2_r_ff;

   // horner chain, powers NUM_COEFS-2 down to 0
   for (genvar k = 0; k < HN; k++) begin : g_horner
      wre_horner_stage #(.FRAC_BITS(FRAC_BITS)) u_stage (
         .clock   (clock),
         .reset   (reset),
         .enable  (en),
         .bypass  ((k == HN - 1) ? recip_ff : 1'b0),
         .ctl_in  (h_ctl[k]),
         .acc_in  (h_acc[k]),
         .r_in    (h_r[k]),
         .coef    (coef_sel[HN-1-k]),
         .ctl_out (h_ctl[k+1]),
         .acc_out (h_acc[k+1]),
         .r_out   (h_r[k+1])
      );
   end

   assign d_ctl[0] = h_ctl[HN];
   assign d_acc[0] = h_acc[HN];
   assign d_r[0]   = h_r[HN];
   assign d_rem[0] = '0;
   assign d_q[0]   = '0;

   // divider chain for |coef_0| * 2^FRAC_BITS / r, msb first
   for (genvar j = 0; j < DW; j++) begin : g_div
      logic din;
      if (DW - 1 - j >= FRAC_BITS) begin : g_hi
         assign din = m0[DW-1-j-FRAC_BITS];
      end else begin : g_lo
         assign din = 1'b0;
      end
      wre_div_stage #(.QW(DW)) u_stage (
         .clock   (clock),
         .reset   (reset),
         .enable  (en),
         .din     (din),
         .ctl_in  (d_ctl[j]),
         .acc_in  (d_acc[j]),
         .r_in    (d_r[j]),
         .rem_in  (d_rem[j]),
         .q_in    (d_q[j]),
         .ctl_out (d_ctl[j+1]),
         .acc_out (d_acc[j+1]),
         .r_out   (d_r[j+1]),
         .rem_out (d_rem[j+1]),
         .q_out   (d_q[j+1])
      );
   end

   // final rounding, reciprocal term, special cases
   assign rnd      = {d_rem[DW], 1'b0} >= {1'b0, d_r[DW]};
   assign res_full = (DW+1)'(d_q[DW]) + (DW+1)'(rnd);
   assign res      = (res_full > (DW+1)'(wre_pkg::MAG_CAP)) ? wre_pkg::MAG_CAP
                                                            : res_full[VW:0];
   assign sres     = coef_ff[0][VW-1] ? -$signed({1'b0, res}) : $signed({1'b0, res});
   assign clip     = wre_pkg::clip_sum((VW+3)'(d_acc[DW]) + (VW+3)'(sres));

   always_comb begin
      out_value_in = d_acc[DW];
      out_sat_in   = d_ctl[DW].flag;
      if (d_ctl[DW].outside) begin
         out_value_in = '0;
         out_sat_in   = 1'b0;
      end else if (d_ctl[DW].rzero) begin
         out_value_in = coef_ff[0][VW-1] ? wre_pkg::NEG_MIN : wre_pkg::POS_MAX;
         out_sat_in   = 1'b1;
      end else if (recip_ff) begin
         out_value_in = clip.value;
         out_sat_in   = d_ctl[DW].flag | clip.clipped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= d_ctl[DW].valid;
      end
      if (en) begin
         out_value_ff <= out_value_in;
         out_sat_ff   <= out_sat_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_value_ff;
   assign rsp_tuser[0] = out_sat_ff;

   a_ready_follows_output : assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow result register");

   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_holds_result : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && !req_tready == !rsp_tready)
      else $error("stalled result lost");

endmodule

/* design/wre_horner_stage.sv */
// wre_horner_stage: acc*r rounded plus coef, or acc when bypassed, in three registers
// depends on wre_pkg
module wre_horner_stage #(
   parameter int FRAC_BITS = wre_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     enable,
   input  logic                                     bypass,
   input  wre_pkg::ctl_type                         ctl_in,
   input  logic signed [wre_pkg::VALUE_W-1:0]       acc_in,
   input  logic        [wre_pkg::DIST_W-1:0]        r_in,
   input  logic signed [wre_pkg::VALUE_W-1:0]       coef,
   output wre_pkg::ctl_type                         ctl_out,
   output logic signed [wre_pkg::VALUE_W-1:0]       acc_out,
   output logic        [wre_pkg::DIST_W-1:0]        r_out
);
   localparam int VW = wre_pkg::VALUE_W;
   localparam int RW = wre_pkg::DIST_W;
   localparam int PW = VW + RW;

   wre_pkg::ctl_type ctl1_ff, ctl2_ff, ctl3_ff, ctl3_in;
   logic [RW-1:0]          r1_ff, r2_ff, r3_ff;
   logic signed [VW-1:0]   acc1_ff, acc2_ff, acc3_ff, acc3_in;
   logic                   neg1_ff, neg2_ff;
   logic [VW-1:0]          mag_in;
   logic [2*RW-1:0]        p0_ff, p0_in;
   logic [VW-1:0]          p1_ff, p1_in;
   logic [PW-1:0]          prod;
   logic [VW:0]            mag2_ff, mag2_in;
   logic signed [VW+1:0]   smag;
   logic signed [VW+2:0]   sum;
   wre_pkg::clip_type      clip;

   // stage 1: magnitude times r as two partial products
   assign mag_in = acc_in[VW-1] ? VW'(-acc_in) : VW'(acc_in);
   assign p0_in  = (2*RW)'(mag_in[RW-1:0]) * (2*RW)'(r_in);
   assign p1_in  = VW'(mag_in[VW-1:RW]) * VW'(r_in);

   // stage 2: combine, round half away from zero, cap magnitude
   assign prod    = PW'(p0_ff) + (PW'(p1_ff) << RW) + (PW'(1) << (FRAC_BITS - 1));
   assign mag2_in = ((prod >> FRAC_BITS) > PW'(wre_pkg::MAG_CAP)) ? wre_pkg::MAG_CAP
                                                                  : (VW+1)'(prod >> FRAC_BITS);

   // stage 3: restore sign, add coefficient, clip
   assign smag = neg2_ff ? -$signed({1'b0, mag2_ff}) : $signed({1'b0, mag2_ff});
   assign sum  = (VW+3)'(smag) + (VW+3)'(coef);
   assign clip = wre_pkg::clip_sum(sum);

   always_comb begin
      ctl3_in = ctl2_ff;
      acc3_in = acc2_ff;
      if (!bypass) begin
         acc3_in      = clip.value;
         ctl3_in.flag = ctl2_ff.flag | clip.clipped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (enable) begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl3_in;
      end
      if (enable) begin
         r1_ff   <= r_in;
         acc1_ff <= acc_in;
         neg1_ff <= acc_in[VW-1];
         p0_ff   <= p0_in;
         p1_ff   <= p1_in;
         r2_ff   <= r1_ff;
         acc2_ff <= acc1_ff;
         neg2_ff <= neg1_ff;
         mag2_ff <= mag2_in;
         r3_ff   <= r2_ff;
         acc3_ff <= acc3_in;
      end
   end

   assign ctl_out = ctl3_ff;
   assign acc_out = acc3_ff;
   assign r_out   = r3_ff;

endmodule

/* design/wre_div_stage.sv */
// wre_div_stage: one restoring division step, one quotient bit per register
// depends on wre_pkg
module wre_div_stage #(
   parameter int QW = wre_pkg::VALUE_W + wre_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  logic                                 din,
   input  wre_pkg::ctl_type                     ctl_in,
   input  logic signed [wre_pkg::VALUE_W-1:0]   acc_in,
   input  logic        [wre_pkg::DIST_W-1:0]    r_in,
   input  logic        [wre_pkg::DIST_W-1:0]    rem_in,
   input  logic        [QW-1:0]                 q_in,
   output wre_pkg::ctl_type                     ctl_out,
   output logic signed [wre_pkg::VALUE_W-1:0]   acc_out,
   output logic        [wre_pkg::DIST_W-1:0]    r_out,
   output logic        [wre_pkg::DIST_W-1:0]    rem_out,
   output logic        [QW-1:0]                 q_out
);
   localparam int RW = wre_pkg::DIST_W;

   wre_pkg::ctl_type ctl_ff;
   logic signed [wre_pkg::VALUE_W-1:0] acc_ff;
   logic [RW-1:0] r_ff, rem_ff, rem_in_next;
   logic [QW-1:0] q_ff, q_in_next;
   logic [RW:0]   cur;
   logic          ge;

   assign cur         = {rem_in, din};
   assign ge          = cur >= {1'b0, r_in};
   assign rem_in_next = ge ? RW'(cur - {1'b0, r_in}) : cur[RW-1:0];
   assign q_in_next   = {q_in[QW-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
      end
      if (enable) begin
         acc_ff <= acc_in;
         r_ff   <= r_in;
         rem_ff <= rem_in_next;
         q_ff   <= q_in_next;
      end
   end

   assign ctl_out = ctl_ff;
   assign acc_out = acc_ff;
   assign r_out   = r_ff;
   assign rem_out = rem_ff;
   assign q_out   = q_ff;

endmodule

/* verif/wre_scoreboard.sv */
// wre_scoreboard: watches the request, response and csr channels of the evaluator,
// predicts each response from its own copy of the registers and compares; depends on wre_pkg
module wre_scoreboard (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // distance
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [47:0]                     rsp_tdata,   // value
   input  logic [0:0]                      rsp_tuser,   // saturated
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [wre_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [47:0]                     csr_data,
   output int                              mismatches,
   output int                              outstanding,
   output int                              responses
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     NCOEF = wre_pkg::NUM_COEFS_DEF;
   localparam int     FRAC  = wre_pkg::FRAC_BITS_DEF;
   localparam int     VW    = wre_pkg::VALUE_W;
   localparam longint HI    = 64'sd140737488355327;
   localparam longint LO    = -64'sd140737488355328;
   localparam longint CAP   = 64'sd281474976710656;

   typedef struct packed {
      logic signed [VW-1:0] value;
      logic                 saturated;
   } rbf_result_type;

   logic [wre_pkg::DIST_W-1:0] support_scale;
   logic                       recip_mode;
   logic signed [VW-1:0]       coefs [0:7];
   rbf_result_type             expected_results [$];

   function automatic longint clip_acc(input longint v, inout bit flag);
      if (v > HI) begin
         flag = 1'b1;
         return HI;
      end
      if (v < LO) begin
         flag = 1'b1;
         return LO;
      end
      return v;
   endfunction

   function automatic longint scale_by_r(input longint acc, input logic [31:0] r);
      logic [127:0] mag;
      logic [127:0] p;
      mag = (acc < 0) ? 128'(-acc) : 128'(acc);
      p = mag * {96'b0, r} + (128'd1 << (FRAC - 1));
      p = p >> FRAC;
      if (p > 128'(CAP)) p = 128'(CAP);
      return (acc < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint coef0_over_r(input longint c0, input logic [31:0] r);
      logic [127:0] num;
      logic [127:0] q;
      logic [127:0] rem;
      num = ((c0 < 0) ? 128'(-c0) : 128'(c0)) << FRAC;
      q = num / {96'b0, r};
      rem = num % {96'b0, r};
      if (q >= (128'd1 << 48)) begin
         q = 128'(CAP);
      end else begin
         if (2 * rem >= {96'b0, r}) q = q + 1;
         if (q > 128'(CAP)) q = 128'(CAP);
      end
      return (c0 < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic rbf_result_type evaluate_rbf(input logic [31:0] r);
      rbf_result_type res;
      logic [63:0]    prod;
      longint         acc;
      bit             flag;
      int             stop;
      prod = {32'b0, support_scale} * {32'b0, r};
      flag = 1'b0;
      acc = 0;
      if (prod >= (64'd1 << (2 * FRAC))) begin
         res.value = '0;
         res.saturated = 1'b0;
         return res;
      end
      if (recip_mode && r == 0) begin
         res.value = (coefs[0] >= 0) ? wre_pkg::POS_MAX : wre_pkg::NEG_MIN;
         res.saturated = 1'b1;
         return res;
      end
      stop = recip_mode ? 1 : 0;
      for (int i = NCOEF - 1; i >= stop; i--) begin
         acc = clip_acc(scale_by_r(acc, r) + longint'(coefs[i]), flag);
      end
      if (recip_mode) acc = clip_acc(acc + coef0_over_r(longint'(coefs[0]), r), flag);
      res.value = acc[VW-1:0];
      res.saturated = flag;
      return res;
   endfunction

   always @(posedge clock) begin
      rbf_result_type want;
      if (reset) begin
         support_scale = wre_pkg::SCALE_RESET;
         recip_mode = 1'b0;
         for (int i = 0; i < 8; i++) coefs[i] = '0;
         expected_results.delete();
         mismatches <= 0;
         responses <= 0;
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == wre_pkg::REG_SCALE) begin
               support_scale = csr_data[wre_pkg::DIST_W-1:0];
            end else if (csr_index == wre_pkg::REG_RECIP) begin
               recip_mode = csr_data[0];
            end else if (csr_index >= wre_pkg::REG_COEF0 &&
                         csr_index < wre_pkg::REG_COEF0 + wre_pkg::REG_COEFS) begin
               coefs[csr_index - wre_pkg::REG_COEF0] = csr_data;
            end
         end
         if (req_tvalid && req_tready) expected_results.push_back(evaluate_rbf(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            responses <= responses + 1;
            if (expected_results.size() == 0) begin
               $display("%0t unexpected response: expected none, actual value %h saturated %b",
                        $realtime, rsp_tdata, rsp_tuser);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_results.pop_front();
               if (want.value !== rsp_tdata || want.saturated !== rsp_tuser[0]) begin
                  $display("%0t mismatch: expected value %h saturated %b,",
                           $realtime, want.value, want.saturated);
                  $display("%0t    actual value %h saturated %b",
                           $realtime, rsp_tdata, rsp_tuser);
                  mismatches <= mismatches + 1;
               end
            end
         end
         outstanding <= expected_results.size();
      end
   end

endmodule

/* verif/wendland_rbf_evaluator_top_test.sv */
// wendland_rbf_evaluator_top_test: clock, reset, csr setup, directed and random distances
// with random gaps and stalls; depends on wre_pkg, wre_scoreboard and the evaluator rtl
module wendland_rbf_evaluator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          IW         = wre_pkg::CSR_INDEX_W;
   localparam logic [IW-1:0] REG_UNUSED = IW'(int'(wre_pkg::REG_COEF0) + wre_pkg::REG_COEFS);
   localparam int          DRAIN      = 100;
   localparam int          LIMIT      = 600000;
   localparam int          PHASES     = 10;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [31:0]            req_tdata;   // distance
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [47:0]            rsp_tdata;   // value
   logic [0:0]             rsp_tuser;   // saturated
   logic                   csr_valid;
   logic                   csr_ready;
   logic [IW-1:0]          csr_index;
   logic [47:0]            csr_data;
   int                     mismatches;
   int                     outstanding;
   int                     responses;
   int                     cycles;
   int                     stall_left;
   bit                     no_idle;
   logic [31:0]            scale_now;

   wendland_rbf_evaluator_top uut (.*);

   wre_scoreboard checker_i (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // response side stall
   always @(posedge clock) begin
      int nxt;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (rsp_tvalid && rsp_tready) begin
         nxt = no_idle ? 0 : $urandom_range(0, 9);
         stall_left <= nxt;
         rsp_tready <= (nxt == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [IW-1:0] coef_index(input int c);
      return IW'(int'(wre_pkg::REG_COEF0) + c);
   endfunction

   task automatic write_reg(input logic [IW-1:0] idx, input logic [47:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == wre_pkg::REG_SCALE) scale_now = data[31:0];
   endtask

   task automatic drain_results();
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic send_distance(input logic [31:0] r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= r;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [47:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return wre_pkg::POS_MAX;
         1: return wre_pkg::NEG_MIN;
         2: return 48'({$urandom(), $urandom()});
         3: return 48'(signed'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000);
         4: return 48'(signed'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
         default: return 48'(signed'($urandom_range(0, 32'h3FFF)) - 32'sh2000);
      endcase
   endfunction

   function automatic logic [31:0] pick_distance();
      logic [63:0] bound;
      if ($urandom_range(0, 9) < 3 || scale_now == 0) return $urandom();
      bound = (64'd1 << 48) / scale_now;
      if (bound > 64'hFFFF_FFFF) bound = 64'hFFFF_FFFF;
      if (bound == 0) return $urandom_range(0, 3);
      return $urandom_range(0, 32'(bound));
   endfunction

   initial begin
      logic [31:0] scale_set;
      cycles = 0;
      no_idle = 1'b0;
      scale_now = wre_pkg::SCALE_RESET;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: plain polynomial at the support edge and extremes
      send_distance(32'h0080_0000);
      end_burst();
      drain_results();
      write_reg(coef_index(0), 48'h0000_0100_0000);
      write_reg(coef_index(1), 48'hFFFF_FD00_0000);
      write_reg(coef_index(2), 48'h0000_0300_0000);
      write_reg(coef_index(3), 48'hFFFF_FF00_0000);
      write_reg(coef_index(4), 48'h0000_0040_0000);
      write_reg(coef_index(5), wre_pkg::POS_MAX);
      write_reg(REG_UNUSED, 48'hABCD_EF01_2345);
      send_distance(32'h0000_0000);
      send_distance(32'h0000_0001);
      send_distance(32'h00FF_FFFF);
      send_distance(32'h0100_0000);
      send_distance(32'hFFFF_FFFF);
      send_distance(32'h0080_0000);
      end_burst();
      drain_results();
      // reciprocal mode, zero distance with both signs, scale zero and max
      write_reg(wre_pkg::REG_RECIP, 48'h1);
      write_reg(wre_pkg::REG_SCALE, 48'h0);
      write_reg(coef_index(5), 48'h0);
      send_distance(32'h0000_0000);
      send_distance(32'h0000_0001);
      send_distance(32'hFFFF_FFFF);
      send_distance(32'h0100_0000);
      end_burst();
      drain_results();
      write_reg(coef_index(0), wre_pkg::NEG_MIN);
      send_distance(32'h0000_0000);
      send_distance(32'h0000_0003);
      send_distance(32'h0040_0000);
      end_burst();
      drain_results();
      write_reg(coef_index(0), wre_pkg::POS_MAX);
      write_reg(wre_pkg::REG_SCALE, 48'hFFFF_FFFF_FFFF);
      send_distance(32'h0000_0000);
      send_distance(32'h0000_FFFF);
      send_distance(32'h0001_0000);
      send_distance(32'h0000_0001);
      end_burst();
      drain_results();

      // random phases with fresh settings
      for (int ph = 0; ph < PHASES; ph++) begin
         case ($urandom_range(0, 5))
            0: scale_set = 32'h0;
            1: scale_set = 32'hFFFF_FFFF;
            2: scale_set = wre_pkg::SCALE_RESET;
            3: scale_set = $urandom_range(1, 32'h00FF_FFFF);
            default: scale_set = $urandom();
         endcase
         write_reg(wre_pkg::REG_SCALE, {16'($urandom()), scale_set});
         write_reg(wre_pkg::REG_RECIP, {47'($urandom()), 1'($urandom())});
         for (int c = 0; c < wre_pkg::REG_COEFS; c++) write_reg(coef_index(c), pick_coef());
         if ($urandom_range(0, 1))
            write_reg(IW'(int'(REG_UNUSED) + int'($urandom_range(0, 7))), {$urandom(), 16'h0});
         no_idle = (ph % 3 == 2);
         for (int n = 0; n < 130; n++) send_distance(pick_distance());
         end_burst();
         drain_results();
      end

      $display("covered %0d responses over %0d random setting phases", responses, PHASES);
      $display("including support edge, scale extremes, reciprocal zero distance and clipping");
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
